@@ rtl/sdii_pkg.sv @@
package sdii_pkg;

	localparam int MAX_WIDTH_DEF = 2048;

	localparam int FRAME_WIDTH_W  = 12;
	localparam int FRAME_HEIGHT_W = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;
	localparam int PIXEL_W        = 8;
	localparam int SQ_W           = 16;
	localparam int VALUE_W        = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd1920;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1080;

	typedef struct packed {
		logic [VALUE_W-1:0] row_sum;
		logic               first_row;
		logic               frame_last;
	} item_info_t;

endpackage

@@ rtl/sdii_ctrl.sv @@
module sdii_ctrl
	import sdii_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      accept,
	input  logic [PIXEL_W-1:0]        cur_pixel,
	input  logic [PIXEL_W-1:0]        ref_pixel,
	output logic [COL_W-1:0]          col,
	output item_info_t                info
);

	localparam int EW = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;

	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [COL_W-1:0]          col_q;
	logic [FRAME_HEIGHT_W-1:0] row_q;
	logic [VALUE_W-1:0]        row_sum_q;

	logic [EW-1:0]             eff_w;
	logic [FRAME_HEIGHT_W-1:0] eff_h;
	logic [EW-1:0]             col_ext;
	logic                      row_end;
	logic                      frame_end;
	logic [PIXEL_W-1:0]        diff;
	logic [SQ_W-1:0]           sq;
	logic [VALUE_W-1:0]        sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0)
			eff_w = EW'(1);
		else if (EW'(frame_width_q) > EW'(MAX_WIDTH))
			eff_w = EW'(MAX_WIDTH);
		else
			eff_w = EW'(frame_width_q);
		eff_h = (frame_height_q == '0) ? FRAME_HEIGHT_W'(1) : frame_height_q;

		col_ext = EW'(col_q);
		if (col_ext >= eff_w)
			col = COL_W'(eff_w - EW'(1));
		else
			col = col_q;

		row_end   = (col_ext + EW'(1)) >= eff_w;
		frame_end = row_end &&
			(({1'b0, row_q} + (FRAME_HEIGHT_W+1)'(1)) >= {1'b0, eff_h});

		diff    = (cur_pixel >= ref_pixel) ? (cur_pixel - ref_pixel) : (ref_pixel - cur_pixel);
		sq      = SQ_W'(diff) * SQ_W'(diff);
		sum_new = row_sum_q + VALUE_W'(sq);

		info.row_sum    = sum_new;
		info.first_row  = (row_q == '0);
		info.frame_last = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q     <= '0;
				row_sum_q <= '0;
				row_q     <= frame_end ? '0 : row_q + FRAME_HEIGHT_W'(1);
			end else begin
				col_q     <= col_q + COL_W'(1);
				row_sum_q <= sum_new;
			end
		end
	end

endmodule

@@ rtl/sdii_linebuf.sv @@
module sdii_linebuf
	import sdii_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [COL_W-1:0]   rd_addr,
	output logic [VALUE_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [COL_W-1:0]   wr_addr,
	input  logic [VALUE_W-1:0] wr_data
);

	logic [VALUE_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/squared_difference_integral_image.sv @@
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   cur_pixel, ref_pixel
// out      output     out_valid / out_stall integral_value, frame_last
// cfg      input      cfg_we                cfg_index, cfg_data
//
// one pixel pair per cycle unless in_stall; a result passes the read stage and output register
// the row above comes from a single line memory, read on transfer, written on read stage advance
// a read of the entry being written in the same cycle is forwarded from a register
// arst_n clears counters, row sum and valids; width and height return to 1920 and 1080
// in_stall rises only when the read stage and the output register are full and out_stall is high
module squared_difference_integral_image
	import sdii_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PIXEL_W-1:0]     cur_pixel,
	input  logic [PIXEL_W-1:0]     ref_pixel,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_W-1:0]     integral_value,
	output logic                   frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic               accept;
	logic               adv;
	logic [COL_W-1:0]   col;
	item_info_t         info;
	logic [VALUE_W-1:0] rd_data;

	logic               valid_s1;
	logic [COL_W-1:0]   col_s1;
	item_info_t         info_s1;
	logic               fwd_q;
	logic [VALUE_W-1:0] fwd_data_q;
	logic [VALUE_W-1:0] above;
	logic [VALUE_W-1:0] value;

	logic               out_valid_q;
	logic [VALUE_W-1:0] integral_value_q;
	logic               frame_last_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	sdii_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cur_pixel (cur_pixel),
		.ref_pixel (ref_pixel),
		.col       (col),
		.info      (info)
	);

	sdii_linebuf #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data (value)
	);

	always_comb begin
		above = fwd_q ? fwd_data_q : rd_data;
		value = info_s1.row_sum + (info_s1.first_row ? '0 : above);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_q    <= adv && (col_s1 == col);
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col;
			info_s1    <= info;
			fwd_data_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			integral_value_q <= value;
			frame_last_q     <= info_s1.frame_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign integral_value = integral_value_q;
	assign frame_last     = frame_last_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("transfer did not reach the read stage");

	a_forward_on_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && adv && (col_s1 == col)) |=> fwd_q)
		else $error("same-entry read and write not forwarded");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result lost between read stage and output register");

endmodule
